// ===== sv/nec_ir_frame_transmitter_top_defines.svh =====
// Assertion macros used by the checker of the NEC IR transmitter.
`ifndef NEC_IR_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define NEC_IR_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define NIRT_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define NIRT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/nirt_pkg.sv =====
// Package: types, constants and codes of the NEC IR frame transmitter.
package nirt_pkg;

    localparam int PAYLOAD_BITS  = 32;
    localparam int TICK_WIDTH    = 16;
    localparam int LAST_DATA_SEG = 2 + 2 * PAYLOAD_BITS;
    localparam int LAST_REP_SEG  = 2;
    localparam int SEG_IDX_W     = $clog2(LAST_DATA_SEG + 1);
    localparam int CFG_IDX_W     = 3;

    typedef logic [TICK_WIDTH-1:0]   t_tick;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [SEG_IDX_W-1:0]    t_seg_idx;

    // NEC timings at a 600 kHz tick
    localparam t_tick LEAD_MARK_RST    = TICK_WIDTH'(5400);
    localparam t_tick HEADER_SPACE_RST = TICK_WIDTH'(2700);
    localparam t_tick REPEAT_SPACE_RST = TICK_WIDTH'(1350);
    localparam t_tick BIT_MARK_RST     = TICK_WIDTH'(337);
    localparam t_tick ONE_SPACE_RST    = TICK_WIDTH'(1012);
    localparam t_tick PERIOD_RST       = TICK_WIDTH'(64800);

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_STANDARD = 3'd1,
        MODE_EXTENDED = 3'd2,
        MODE_RAW      = 3'd3,
        MODE_STOP     = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAD_MARK    = 3'd0,
        CFG_HEADER_SPACE = 3'd1,
        CFG_REPEAT_SPACE = 3'd2,
        CFG_BIT_MARK     = 3'd3,
        CFG_ONE_SPACE    = 3'd4,
        CFG_PERIOD       = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_IDLE   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_REPEAT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [7:0]  command;
        logic [31:0] raw_word;
        logic [15:0] rep_count;
    } t_item;

    // led_mark in the lowest bit
    typedef struct packed {
        t_kind   frame_kind;
        t_status send_status;
        logic    busy_res;
        logic    led_mark;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== sv/nec_ir_frame_transmitter_top.sv =====
// Top level of the NEC IR frame transmitter: stream ports and output buffering.
// Each accepted input word is one modulator tick, a send command or a stop, and yields exactly
// one output word: the LED envelope level, busy, the send status and the frame kind, all taken
// after that word's update. The block takes one word per clock while s_axis_tready is high; the
// result is registered in the output register, or in the skid register if that one is held. The
// two-entry buffer keeps s_axis_tready high while one result waits, so the rate is one word per
// cycle whenever the sink takes one per cycle, and input stalls only when both entries are full.
// A send is rejected (status 2) while a frame or its repeat codes are in progress; busy clears
// at the first repeat-period end with no repeats left. Configuration registers (index 0..5:
// lead mark, header space, repeat space, bit mark, one space, repeat period, all in ticks)
// are written with i_cfg_we and must only change while the block is idle; a zero length counts
// as one tick.
module nec_ir_frame_transmitter_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nirt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [nirt_pkg::TICK_WIDTH-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: address[15:0], command[23:16], raw_word[55:24], rep_count[71:56]
    input  logic [71:0]                          s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [2:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: led_mark[0], busy_res[1], send_status[3:2], frame_kind[5:4], zero[7:6]
    output logic [7:0]                           m_axis_tdata
);

    logic              in_acc;
    logic              out_take;
    nirt_pkg::t_item   item;
    nirt_pkg::t_result result;

    logic              r_out_valid;
    nirt_pkg::t_result r_out_data;
    logic              r_skid_valid;
    nirt_pkg::t_result r_skid_data;

    // accept while the skid entry is free
    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    always_comb begin
        item.mode      = s_axis_tuser;
        item.address   = s_axis_tdata[15:0];
        item.command   = s_axis_tdata[23:16];
        item.raw_word  = s_axis_tdata[55:24];
        item.rep_count = s_axis_tdata[71:56];
    end

    nirt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_acc),
        .i_item     (item),
        .o_result   (result)
    );

    // control of the two result entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            // output entry frees up: refill from skid first, else from the new word
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            // output entry held: park the new word
            r_skid_valid <= 1'b1;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end else if (in_acc) begin
            r_skid_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(8 - nirt_pkg::RESULT_W)'(0), r_out_data};

endmodule

// ===== sv/nirt_core.sv =====
// Core: configuration registers, envelope and repeat-period state update.
module nirt_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nirt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nirt_pkg::TICK_WIDTH-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  nirt_pkg::t_item                    i_item,
    output nirt_pkg::t_result                  o_result
);

    nirt_pkg::t_tick    r_lead, r_header, r_rep_space, r_bit_mark, r_one_space, r_period;

    logic               r_busy, n_busy;
    logic [15:0]        r_repeats, n_repeats;
    nirt_pkg::t_payload r_pay, n_pay;
    nirt_pkg::t_seg_idx r_seg_idx, n_seg_idx;
    nirt_pkg::t_tick    r_seg_rem, n_seg_rem;
    nirt_pkg::t_tick    r_per_rem, n_per_rem;
    nirt_pkg::t_kind    r_kind, n_kind;
    nirt_pkg::t_status  status;

    nirt_pkg::t_seg_idx seg_next;
    nirt_pkg::t_tick    next_len;
    nirt_pkg::t_seg_idx last_seg;
    logic [31:0]        send_word;
    logic [15:0]        cmd_part;

    function automatic nirt_pkg::t_tick at_least_one(input nirt_pkg::t_tick v);
        return (v == '0) ? nirt_pkg::t_tick'(1) : v;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead      <= nirt_pkg::LEAD_MARK_RST;
            r_header    <= nirt_pkg::HEADER_SPACE_RST;
            r_rep_space <= nirt_pkg::REPEAT_SPACE_RST;
            r_bit_mark  <= nirt_pkg::BIT_MARK_RST;
            r_one_space <= nirt_pkg::ONE_SPACE_RST;
            r_period    <= nirt_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (nirt_pkg::t_cfg_reg'(i_cfg_idx))
                nirt_pkg::CFG_LEAD_MARK:    r_lead      <= i_cfg_data;
                nirt_pkg::CFG_HEADER_SPACE: r_header    <= i_cfg_data;
                nirt_pkg::CFG_REPEAT_SPACE: r_rep_space <= i_cfg_data;
                nirt_pkg::CFG_BIT_MARK:     r_bit_mark  <= i_cfg_data;
                nirt_pkg::CFG_ONE_SPACE:    r_one_space <= i_cfg_data;
                nirt_pkg::CFG_PERIOD:       r_period    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // length of the segment that follows the current one
    always_comb begin
        seg_next = r_seg_idx + nirt_pkg::t_seg_idx'(1);
        last_seg = (r_kind == nirt_pkg::KIND_DATA)
                 ? nirt_pkg::t_seg_idx'(nirt_pkg::LAST_DATA_SEG)
                 : nirt_pkg::t_seg_idx'(nirt_pkg::LAST_REP_SEG);
        if (r_kind == nirt_pkg::KIND_REPEAT) begin
            next_len = (seg_next == nirt_pkg::t_seg_idx'(1)) ? r_rep_space : r_bit_mark;
        end else if (seg_next == nirt_pkg::t_seg_idx'(1)) begin
            next_len = r_header;
        end else if (seg_next[0] && seg_next < nirt_pkg::t_seg_idx'(nirt_pkg::LAST_DATA_SEG)) begin
            next_len = r_pay[0] ? r_one_space : r_bit_mark;
        end else begin
            next_len = r_bit_mark;
        end
        next_len = at_least_one(next_len);
    end

    // payload word of a send
    always_comb begin
        cmd_part = {~i_item.command, i_item.command};
        unique case (nirt_pkg::t_mode'(i_item.mode))
            nirt_pkg::MODE_STANDARD:
                send_word = {cmd_part, ~i_item.address[7:0], i_item.address[7:0]};
            nirt_pkg::MODE_EXTENDED:
                send_word = {cmd_part, i_item.address};
            default:
                send_word = i_item.raw_word;
        endcase
    end

    always_comb begin
        n_busy    = r_busy;
        n_repeats = r_repeats;
        n_pay     = r_pay;
        n_seg_idx = r_seg_idx;
        n_seg_rem = r_seg_rem;
        n_per_rem = r_per_rem;
        n_kind    = r_kind;
        status    = nirt_pkg::ST_NONE;

        unique case (nirt_pkg::t_mode'(i_item.mode)) inside
            nirt_pkg::MODE_TICK: begin
                // advance the envelope
                if (r_kind != nirt_pkg::KIND_IDLE) begin
                    if (r_seg_rem > nirt_pkg::t_tick'(1)) begin
                        n_seg_rem = r_seg_rem - nirt_pkg::t_tick'(1);
                    end else if (r_seg_idx >= last_seg) begin
                        n_kind    = nirt_pkg::KIND_IDLE;
                        n_seg_idx = '0;
                        n_seg_rem = '0;
                    end else begin
                        // drop the sent bit when leaving its space
                        if (r_kind == nirt_pkg::KIND_DATA && r_seg_idx[0] &&
                            r_seg_idx >= nirt_pkg::t_seg_idx'(3)) begin
                            n_pay = r_pay >> 1;
                        end
                        n_seg_idx = seg_next;
                        n_seg_rem = next_len;
                    end
                end
                // advance the repeat period; its end overrides the envelope
                if (r_busy) begin
                    if (r_per_rem > nirt_pkg::t_tick'(1)) begin
                        n_per_rem = r_per_rem - nirt_pkg::t_tick'(1);
                    end else if (r_repeats != '0) begin
                        n_repeats = r_repeats - 16'd1;
                        n_per_rem = at_least_one(r_period);
                        n_kind    = nirt_pkg::KIND_REPEAT;
                        n_seg_idx = '0;
                        n_seg_rem = at_least_one(r_lead);
                    end else begin
                        n_busy    = 1'b0;
                        n_per_rem = '0;
                        n_kind    = nirt_pkg::KIND_IDLE;
                        n_seg_idx = '0;
                        n_seg_rem = '0;
                    end
                end
            end
            nirt_pkg::MODE_STANDARD, nirt_pkg::MODE_EXTENDED, nirt_pkg::MODE_RAW: begin
                if (r_busy) begin
                    status = nirt_pkg::ST_REJECT;
                end else begin
                    status    = nirt_pkg::ST_ACCEPT;
                    n_busy    = 1'b1;
                    n_repeats = i_item.rep_count;
                    n_pay     = nirt_pkg::PAYLOAD_BITS'(send_word);
                    n_per_rem = at_least_one(r_period);
                    n_kind    = nirt_pkg::KIND_DATA;
                    n_seg_idx = '0;
                    n_seg_rem = at_least_one(r_lead);
                end
            end
            nirt_pkg::MODE_STOP: begin
                n_repeats = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_repeats <= '0;
            r_pay     <= '0;
            r_seg_idx <= '0;
            r_seg_rem <= '0;
            r_per_rem <= '0;
            r_kind    <= nirt_pkg::KIND_IDLE;
        end else if (i_accept) begin
            r_busy    <= n_busy;
            r_repeats <= n_repeats;
            r_pay     <= n_pay;
            r_seg_idx <= n_seg_idx;
            r_seg_rem <= n_seg_rem;
            r_per_rem <= n_per_rem;
            r_kind    <= n_kind;
        end
    end

    always_comb begin
        o_result.led_mark    = (n_kind != nirt_pkg::KIND_IDLE) && !n_seg_idx[0];
        o_result.busy_res    = n_busy;
        o_result.send_status = status;
        o_result.frame_kind  = n_kind;
    end

endmodule

// ===== sv/nirt_checker.sv =====
// Port-level checker of the NEC IR frame transmitter, bound to the top level.
`include "nec_ir_frame_transmitter_top_defines.svh"

module nirt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata
);

    `NIRT_CHECK_NOW(a_idle_dark,
        m_axis_tvalid && m_axis_tdata[5:4] == nirt_pkg::KIND_IDLE,
        !m_axis_tdata[0],
        "led mark set while no frame is playing")

    `NIRT_CHECK_NOW(a_accept_starts_lead,
        m_axis_tvalid && m_axis_tdata[3:2] == nirt_pkg::ST_ACCEPT,
        m_axis_tdata[1] && m_axis_tdata[0] && m_axis_tdata[5:4] == nirt_pkg::KIND_DATA,
        "accepted send did not start a data frame with its leading mark")

    `NIRT_CHECK_NOW(a_reject_when_busy,
        m_axis_tvalid && m_axis_tdata[3:2] == nirt_pkg::ST_REJECT,
        m_axis_tdata[1],
        "send rejected while not busy")

    `NIRT_CHECK_NOW(a_not_busy_idle,
        m_axis_tvalid && !m_axis_tdata[1],
        m_axis_tdata[5:4] == nirt_pkg::KIND_IDLE,
        "frame playing while busy is clear")

    `NIRT_CHECK_NEXT(a_out_hold,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata),
        "stalled output word changed")

endmodule

bind nec_ir_frame_transmitter_top nirt_checker u_nirt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
